// File: rtl/core/oled_frame_store_streamer_assert.svh
// Assertion macros shared by the checker of the frame store streamer.
`ifndef OLED_FRAME_STORE_STREAMER_ASSERT_SVH
`define OLED_FRAME_STORE_STREAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define OFSS_ASSERT_IMPL(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define OFSS_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/core/ofss_pkg.sv
// Shared constants, types and command tables of the OLED frame store streamer.
package ofss_pkg;

    localparam int COLUMNS    = 128;
    localparam int PAGE_COUNT = 4;
    localparam int STORE_SIZE = COLUMNS * PAGE_COUNT;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ADDR_W = $clog2(STORE_SIZE);
    localparam int HEAD_LEN    = 4;
    localparam int DATA_OFFSET = HEAD_LEN + 1;
    localparam int POS_W  = $clog2(COLUMNS + DATA_OFFSET);
    localparam int STEP_W = 4;

    typedef logic [2:0]        cmd_t;
    typedef logic [7:0]        byte_t;
    typedef logic [6:0]        bus_addr_t;
    typedef logic [7:0]        reg_index_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [1:0]        mode_t;

    // Command codes
    localparam cmd_t CMD_SET_PIXEL = 3'd0;
    localparam cmd_t CMD_FILL      = 3'd1;
    localparam cmd_t CMD_FLUSH     = 3'd2;
    localparam cmd_t CMD_INIT      = 3'd3;
    localparam cmd_t CMD_TEST      = 3'd4;
    localparam cmd_t CMD_TICK      = 3'd5;

    // Sequence modes
    localparam mode_t MODE_IDLE  = 2'd0;
    localparam mode_t MODE_FLUSH = 2'd1;
    localparam mode_t MODE_INIT  = 2'd2;
    localparam mode_t MODE_TEST  = 2'd3;

    // Register indexes
    localparam reg_index_t REG_BUS_ADDRESS = 8'd0;
    localparam reg_index_t REG_CONTRAST    = 8'd1;

    localparam bus_addr_t BUS_ADDRESS_RESET = 7'd60;
    localparam byte_t     CONTRAST_RESET    = 8'd143;

    // Payload bytes
    localparam byte_t BYTE_CTRL_CMD  = 8'h00;
    localparam byte_t BYTE_CTRL_DATA = 8'h40;
    localparam byte_t BYTE_SET_PAGE  = 8'hB0;
    localparam byte_t BYTE_COL_LOW   = 8'h00;
    localparam byte_t BYTE_COL_HIGH  = 8'h10;
    localparam byte_t BYTE_TEST      = 8'hA5;

    localparam logic [8:0] X_LIMIT = 9'(COLUMNS);
    localparam logic [8:0] Y_LIMIT = 9'(8 * PAGE_COUNT);

    localparam step_t INIT_LAST_STEP     = 4'd15;
    localparam step_t INIT_CONTRAST_SLOT = 4'd10;

    // Number of bytes after the control byte in each init transfer.
    function automatic logic [1:0] init_len_f(input step_t step);
        logic [1:0] len;
        case (step)
            4'd0, 4'd4, 4'd7, 4'd8, 4'd13, 4'd14, 4'd15: len = 2'd1;
            default: len = 2'd2;
        endcase
        return len;
    endfunction

    // Command bytes of the init list; sel picks the second byte.
    function automatic byte_t init_byte_f(input step_t step, input logic sel);
        byte_t b0;
        byte_t b1;
        b1 = 8'h00;
        case (step)
            4'd0:    b0 = 8'hAE;
            4'd1:    begin b0 = 8'hD5; b1 = 8'h80; end
            4'd2:    begin b0 = 8'hA8; b1 = 8'h1F; end
            4'd3:    begin b0 = 8'hD3; b1 = 8'h00; end
            4'd4:    b0 = 8'h40;
            4'd5:    begin b0 = 8'h8D; b1 = 8'h14; end
            4'd6:    begin b0 = 8'h20; b1 = 8'h02; end
            4'd7:    b0 = 8'hA1;
            4'd8:    b0 = 8'hC8;
            4'd9:    begin b0 = 8'hDA; b1 = 8'h02; end
            4'd10:   b0 = 8'h81;
            4'd11:   begin b0 = 8'hD9; b1 = 8'hF1; end
            4'd12:   begin b0 = 8'hDB; b1 = 8'h40; end
            4'd13:   b0 = 8'hA4;
            4'd14:   b0 = 8'hA6;
            default: b0 = 8'hAF;
        endcase
        return sel ? b1 : b0;
    endfunction

    // Page-organized store address of one column.
    function automatic addr_t store_addr(input page_t page, input col_t col);
        return addr_t'(int'(page) * COLUMNS + int'(col));
    endfunction

endpackage

// File: rtl/core/ofss_if.sv
// Channel interfaces of the frame store streamer: command, result and register write.
interface ofss_req_if;
    import ofss_pkg::*;
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    byte_t pixel_x;
    byte_t pixel_y;
    logic  pixel_on;
    byte_t fill_byte;
    modport source (output valid, cmd, pixel_x, pixel_y, pixel_on, fill_byte, input ready);
    modport sink   (input valid, cmd, pixel_x, pixel_y, pixel_on, fill_byte, output ready);
endinterface

interface ofss_rsp_if;
    import ofss_pkg::*;
    logic      valid;
    logic      ready;
    byte_t     byte_value;
    logic      transfer_first;
    logic      transfer_last;
    logic      sequence_last;
    bus_addr_t target_address;
    modport source (output valid, byte_value, transfer_first, transfer_last, sequence_last,
                    target_address, input ready);
    modport sink   (input valid, byte_value, transfer_first, transfer_last, sequence_last,
                    target_address, output ready);
endinterface

interface ofss_cfg_if;
    import ofss_pkg::*;
    logic       valid;
    logic       ready;
    reg_index_t index;
    byte_t      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/oled_frame_store_streamer.sv
// Top level: page-organized frame store and OLED payload word streamer.
//
//  channel | dir | words                                   | accepted when
//  req     | in  | cmd, pixel_x, pixel_y, pixel_on, fill   | req.valid & req.ready
//  rsp     | out | byte_value, flags, target_address       | rsp.valid & rsp.ready
//  cfg     | in  | index, data                             | cfg.valid & cfg.ready
//
// A tick that emits a word, or an in-range set_pixel, reads the frame store on acceptance and
// then passes through ST_EMIT or ST_RMW to emit the word or write the modified byte back.
// Fill and init sweep the store, one entry a cycle, so req stalls until all 512 are written.
// After reset a clearing pass over all 512 entries runs before the first req word is taken.
// A result word waiting on rsp holds off every req word. cfg is always ready.
module oled_frame_store_streamer (
    input logic         clk,
    input logic         rst_n,
    ofss_req_if.sink    req,
    ofss_rsp_if.source  rsp,
    ofss_cfg_if.sink    cfg
);
    import ofss_pkg::*;

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RMW   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    addr_t      sweep_addr_reg, sweep_addr_next;
    byte_t      sweep_data_reg, sweep_data_next;
    mode_t      mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    page_t      page_reg, page_next;
    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    bus_addr_t  bus_address_reg;
    byte_t      contrast_reg;

    addr_t      rmw_addr_reg, rmw_addr_next;
    byte_t      rmw_mask_reg, rmw_mask_next;
    logic       rmw_on_reg, rmw_on_next;
    byte_t      emit_val_reg, emit_val_next;
    logic       emit_first_reg, emit_first_next;
    logic       emit_last_reg, emit_last_next;
    logic       emit_seq_reg, emit_seq_next;
    logic       emit_mem_reg, emit_mem_next;
    byte_t      out_val_reg, out_val_next;
    logic       out_first_reg, out_first_next;
    logic       out_last_reg, out_last_next;
    logic       out_seq_reg, out_seq_next;
    bus_addr_t  out_addr_reg, out_addr_next;

    byte_t      mem [STORE_SIZE];
    byte_t      mem_rdata_reg;
    logic       mem_we;
    addr_t      mem_waddr;
    byte_t      mem_wdata;
    addr_t      mem_raddr;

    logic       req_fire;
    logic       px_in_range;
    addr_t      px_addr;

    byte_t      t_val;
    logic       t_first, t_last, t_seq, t_use_mem;
    addr_t      t_raddr;
    mode_t      t_mode;
    pos_t       t_pos;
    page_t      t_page;
    step_t      t_step;
    logic [1:0] t_len;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid          = out_valid_reg;
    assign rsp.byte_value     = out_val_reg;
    assign rsp.transfer_first = out_first_reg;
    assign rsp.transfer_last  = out_last_reg;
    assign rsp.sequence_last  = out_seq_reg;
    assign rsp.target_address = out_addr_reg;

    assign px_in_range = ({1'b0, req.pixel_x} < X_LIMIT) && ({1'b0, req.pixel_y} < Y_LIMIT);
    assign px_addr     = store_addr(page_t'(req.pixel_y >> 3), col_t'(req.pixel_x));
    assign mem_raddr   = (req.cmd == CMD_SET_PIXEL) ? px_addr : t_raddr;

    // Result and sequence advance for a tick, from the current position.
    always_comb
    begin
        t_val     = BYTE_CTRL_CMD;
        t_first   = 1'b0;
        t_last    = 1'b0;
        t_seq     = 1'b0;
        t_use_mem = 1'b0;
        t_raddr   = store_addr(page_reg, col_t'(pos_reg - pos_t'(DATA_OFFSET)));
        t_mode    = mode_reg;
        t_pos     = pos_reg;
        t_page    = page_reg;
        t_step    = step_reg;
        t_len     = init_len_f(step_reg);
        case (mode_reg)
            MODE_FLUSH:
            begin
                if (pos_reg < pos_t'(HEAD_LEN))
                begin
                    case (pos_reg[1:0])
                        2'd0:    t_val = BYTE_CTRL_CMD;
                        2'd1:    t_val = BYTE_SET_PAGE | byte_t'(page_reg);
                        2'd2:    t_val = BYTE_COL_LOW;
                        default: t_val = BYTE_COL_HIGH;
                    endcase
                    t_first = (pos_reg == '0);
                    t_last  = (pos_reg == pos_t'(HEAD_LEN - 1));
                    t_pos   = pos_reg + pos_t'(1);
                end
                else if (pos_reg == pos_t'(HEAD_LEN))
                begin
                    t_val   = BYTE_CTRL_DATA;
                    t_first = 1'b1;
                    t_pos   = pos_reg + pos_t'(1);
                end
                else
                begin
                    t_use_mem = 1'b1;
                    if (pos_reg >= pos_t'(COLUMNS + HEAD_LEN))
                    begin
                        t_last = 1'b1;
                        t_pos  = '0;
                        if (page_reg == page_t'(PAGE_COUNT - 1))
                        begin
                            t_seq  = 1'b1;
                            t_mode = MODE_IDLE;
                            t_page = '0;
                            t_step = '0;
                        end
                        else
                        begin
                            t_page = page_reg + page_t'(1);
                        end
                    end
                    else
                    begin
                        t_pos = pos_reg + pos_t'(1);
                    end
                end
            end
            MODE_INIT:
            begin
                if (pos_reg == '0)
                begin
                    t_val   = BYTE_CTRL_CMD;
                    t_first = 1'b1;
                end
                else if (step_reg == INIT_CONTRAST_SLOT && !pos_reg[0])
                begin
                    t_val = contrast_reg;
                end
                else
                begin
                    // Position 1 gives the first byte of the pair, position 2 the second.
                    t_val = init_byte_f(step_reg, ~pos_reg[0]);
                end
                if (pos_reg >= pos_t'(t_len))
                begin
                    t_last = 1'b1;
                    t_pos  = '0;
                    if (step_reg == INIT_LAST_STEP)
                    begin
                        t_seq  = 1'b1;
                        t_mode = MODE_IDLE;
                        t_page = '0;
                        t_step = '0;
                    end
                    else
                    begin
                        t_step = step_reg + step_t'(1);
                    end
                end
                else
                begin
                    t_pos = pos_reg + pos_t'(1);
                end
            end
            MODE_TEST:
            begin
                if (pos_reg == '0)
                begin
                    t_val   = BYTE_CTRL_CMD;
                    t_first = 1'b1;
                    t_pos   = pos_t'(1);
                end
                else
                begin
                    t_val  = BYTE_TEST;
                    t_last = 1'b1;
                    t_seq  = 1'b1;
                    t_mode = MODE_IDLE;
                    t_pos  = '0;
                    t_page = '0;
                    t_step = '0;
                end
            end
            default: ;
        endcase
    end

    // Command decode and sequencing.
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_data_next = sweep_data_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        page_next       = page_reg;
        step_next       = step_reg;
        rmw_addr_next   = rmw_addr_reg;
        rmw_mask_next   = rmw_mask_reg;
        rmw_on_next     = rmw_on_reg;
        emit_val_next   = emit_val_reg;
        emit_first_next = emit_first_reg;
        emit_last_next  = emit_last_reg;
        emit_seq_next   = emit_seq_reg;
        emit_mem_next   = emit_mem_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = sweep_data_reg;

        case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                if (sweep_addr_reg == addr_t'(STORE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
                sweep_addr_next = sweep_addr_reg + addr_t'(1);
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.cmd == CMD_TICK)
                    begin
                        if (mode_reg != MODE_IDLE)
                        begin
                            state_next      = ST_EMIT;
                            mode_next       = t_mode;
                            pos_next        = t_pos;
                            page_next       = t_page;
                            step_next       = t_step;
                            emit_val_next   = t_val;
                            emit_first_next = t_first;
                            emit_last_next  = t_last;
                            emit_seq_next   = t_seq;
                            emit_mem_next   = t_use_mem;
                        end
                    end
                    else if (mode_reg == MODE_IDLE)
                    begin
                        case (req.cmd)
                            CMD_SET_PIXEL:
                            begin
                                if (px_in_range)
                                begin
                                    state_next    = ST_RMW;
                                    rmw_addr_next = px_addr;
                                    rmw_mask_next = 8'b1 << req.pixel_y[2:0];
                                    rmw_on_next   = req.pixel_on;
                                end
                            end
                            CMD_FILL:
                            begin
                                state_next      = ST_SWEEP;
                                sweep_addr_next = '0;
                                sweep_data_next = req.fill_byte;
                                mode_next       = MODE_FLUSH;
                            end
                            CMD_FLUSH: mode_next = MODE_FLUSH;
                            CMD_INIT:
                            begin
                                state_next      = ST_SWEEP;
                                sweep_addr_next = '0;
                                sweep_data_next = '0;
                                mode_next       = MODE_INIT;
                            end
                            CMD_TEST: mode_next = MODE_TEST;
                            default: ;
                        endcase
                    end
                end
            end
            ST_RMW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = rmw_addr_reg;
                mem_wdata  = rmw_on_reg ? (mem_rdata_reg | rmw_mask_reg)
                                        : (mem_rdata_reg & ~rmw_mask_reg);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word register; the tick was only accepted with this register free.
    always_comb
    begin
        out_val_next   = out_val_reg;
        out_first_next = out_first_reg;
        out_last_next  = out_last_reg;
        out_seq_next   = out_seq_reg;
        out_addr_next  = out_addr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (state_reg == ST_EMIT)
        begin
            out_valid_next = 1'b1;
            out_val_next   = emit_mem_reg ? mem_rdata_reg : emit_val_reg;
            out_first_next = emit_first_reg;
            out_last_next  = emit_last_reg;
            out_seq_next   = emit_seq_reg;
            out_addr_next  = bus_address_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_data_reg <= '0;
            mode_reg       <= MODE_IDLE;
            pos_reg        <= '0;
            page_reg       <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_data_reg <= sweep_data_next;
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            page_reg       <= page_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_address_reg <= BUS_ADDRESS_RESET;
            contrast_reg    <= CONTRAST_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_BUS_ADDRESS: bus_address_reg <= cfg.data[6:0];
                REG_CONTRAST:    contrast_reg    <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rmw_addr_reg   <= rmw_addr_next;
        rmw_mask_reg   <= rmw_mask_next;
        rmw_on_reg     <= rmw_on_next;
        emit_val_reg   <= emit_val_next;
        emit_first_reg <= emit_first_next;
        emit_last_reg  <= emit_last_next;
        emit_seq_reg   <= emit_seq_next;
        emit_mem_reg   <= emit_mem_next;
        out_val_reg    <= out_val_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
        out_seq_reg    <= out_seq_next;
        out_addr_reg   <= out_addr_next;
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

endmodule

// File: rtl/core/ofss_checker.sv
// Port-level checker of the frame store streamer and its bind to the top level.
`include "oled_frame_store_streamer_assert.svh"

module ofss_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input ofss_pkg::cmd_t req_cmd,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input ofss_pkg::byte_t rsp_byte_value,
    input logic          rsp_transfer_first,
    input logic          rsp_transfer_last,
    input logic          rsp_sequence_last
);
    import ofss_pkg::*;

    logic tick_fire;

    assign tick_fire = req_valid && req_ready && (req_cmd == CMD_TICK);

    // A result word that waits on the sink holds off every input word.
    `OFSS_ASSERT_IMPL(a_stall_holds_input, rsp_valid && !rsp_ready, !req_ready, "input taken while stalled")

    // A new result word comes only from an accepted tick, by way of the emit state and the output register.
    `OFSS_ASSERT_IMPL(a_result_from_tick, $rose(rsp_valid), $past(tick_fire, 2), "word without a tick")

    // The end of a sequence also closes a transfer, and never opens one.
    `OFSS_ASSERT_IMPL(a_seq_end_closes, rsp_valid && rsp_sequence_last, rsp_transfer_last && !rsp_transfer_first, "bad sequence end")

    // A stalled result word stays in place.
    `OFSS_ASSERT_NEXT(a_stalled_word_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte_value), "stalled word changed")

endmodule

bind oled_frame_store_streamer ofss_checker u_ofss_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_cmd            (req.cmd),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_byte_value     (rsp.byte_value),
    .rsp_transfer_first (rsp.transfer_first),
    .rsp_transfer_last  (rsp.transfer_last),
    .rsp_sequence_last  (rsp.sequence_last)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench of the OLED frame store streamer: directed and random command words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ofss_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 600;
    localparam int DRAIN_CYCLES   = 50;
    localparam int RANDOM_ITEMS   = 100;
    localparam int ROWS           = 8 * PAGE_COUNT;

    localparam reg_index_t REG_FIRST_UNUSED = REG_CONTRAST + 8'd1;

    typedef struct packed {
        byte_t     value;
        logic      transfer_first;
        logic      transfer_last;
        logic      sequence_last;
        bus_addr_t address;
    } payload_byte_t;

    logic clk;
    logic rst_n;

    ofss_req_if req_ch ();
    ofss_rsp_if rsp_ch ();
    ofss_cfg_if cfg_ch ();

    oled_frame_store_streamer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the panel state.
    byte_t     frame_image [STORE_SIZE];
    mode_t     seq_mode;
    int        seq_pos;
    int        seq_page;
    int        seq_step;
    bus_addr_t link_address;
    byte_t     contrast_setting;

    payload_byte_t payload_due [$];

    int  mismatches;
    int  items_taken;
    int  tx_calm;
    int  rx_calm;
    int  rx_stall_left;
    bit  back_to_back;
    bit  holdoff_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Init command list: {second byte present, first byte, second byte}.
    function automatic logic [16:0] init_entry(input int step);
        case (step)
            0:       return {1'b0, 8'hAE, 8'h00};
            1:       return {1'b1, 8'hD5, 8'h80};
            2:       return {1'b1, 8'hA8, 8'h1F};
            3:       return {1'b1, 8'hD3, 8'h00};
            4:       return {1'b0, 8'h40, 8'h00};
            5:       return {1'b1, 8'h8D, 8'h14};
            6:       return {1'b1, 8'h20, 8'h02};
            7:       return {1'b0, 8'hA1, 8'h00};
            8:       return {1'b0, 8'hC8, 8'h00};
            9:       return {1'b1, 8'hDA, 8'h02};
            10:      return {1'b1, 8'h81, 8'h00};
            11:      return {1'b1, 8'hD9, 8'hF1};
            12:      return {1'b1, 8'hDB, 8'h40};
            13:      return {1'b0, 8'hA4, 8'h00};
            14:      return {1'b0, 8'hA6, 8'h00};
            default: return {1'b0, 8'hAF, 8'h00};
        endcase
    endfunction

    function automatic void start_sequence(input mode_t mode);
        seq_mode = mode;
        seq_pos  = 0;
        seq_page = 0;
        seq_step = 0;
    endfunction

    // Advances the shadow state by one accepted command word and queues the byte, if any, that it emits.
    function automatic bit stream_command(input cmd_t c, input byte_t x, input byte_t y,
                                          input logic on, input byte_t fill);
        payload_byte_t w;
        logic [16:0]   entry;
        int            len;
        w = '0;
        if (c != CMD_TICK)
        begin
            if (seq_mode != MODE_IDLE)
                return 1'b0;
            case (c)
                CMD_SET_PIXEL:
                begin
                    if (int'(x) < COLUMNS && int'(y) < ROWS)
                        frame_image[int'(y[7:3]) * COLUMNS + int'(x)][y[2:0]] = on;
                end
                CMD_FILL:
                begin
                    foreach (frame_image[i])
                        frame_image[i] = fill;
                    start_sequence(MODE_FLUSH);
                end
                CMD_FLUSH:
                    start_sequence(MODE_FLUSH);
                CMD_INIT:
                begin
                    foreach (frame_image[i])
                        frame_image[i] = 8'h00;
                    start_sequence(MODE_INIT);
                end
                CMD_TEST:
                    start_sequence(MODE_TEST);
                default:
                    return 1'b0;
            endcase
            return 1'b1;
        end
        if (seq_mode == MODE_IDLE)
            return 1'b0;
        w.address = link_address;
        case (seq_mode)
            MODE_FLUSH:
            begin
                if (seq_pos < HEAD_LEN)
                begin
                    case (seq_pos)
                        0:       w.value = BYTE_CTRL_CMD;
                        1:       w.value = BYTE_SET_PAGE | byte_t'(seq_page);
                        2:       w.value = BYTE_COL_LOW;
                        default: w.value = BYTE_COL_HIGH;
                    endcase
                    w.transfer_first = (seq_pos == 0);
                    w.transfer_last  = (seq_pos == HEAD_LEN - 1);
                end
                else if (seq_pos == HEAD_LEN)
                begin
                    w.value          = BYTE_CTRL_DATA;
                    w.transfer_first = 1'b1;
                end
                else
                begin
                    w.value         = frame_image[seq_page * COLUMNS + seq_pos - DATA_OFFSET];
                    w.transfer_last = (seq_pos == COLUMNS + HEAD_LEN);
                end
                // The page header ends a transfer but not the page.
                if (w.transfer_last && seq_pos != HEAD_LEN - 1)
                begin
                    w.sequence_last = (seq_page + 1 >= PAGE_COUNT);
                    if (w.sequence_last)
                    begin
                        start_sequence(MODE_IDLE);
                    end
                    else
                    begin
                        seq_page = seq_page + 1;
                        seq_pos  = 0;
                    end
                end
                else
                begin
                    seq_pos = seq_pos + 1;
                end
            end
            MODE_INIT:
            begin
                entry = init_entry(seq_step);
                len   = entry[16] ? 2 : 1;
                if (seq_pos == 0)
                begin
                    w.value          = BYTE_CTRL_CMD;
                    w.transfer_first = 1'b1;
                end
                else if (seq_pos == 1)
                begin
                    w.value = entry[15:8];
                end
                else if (seq_step == int'(INIT_CONTRAST_SLOT))
                begin
                    w.value = contrast_setting;
                end
                else
                begin
                    w.value = entry[7:0];
                end
                w.transfer_last = (seq_pos >= len);
                if (w.transfer_last)
                begin
                    w.sequence_last = (seq_step == int'(INIT_LAST_STEP));
                    if (w.sequence_last)
                    begin
                        start_sequence(MODE_IDLE);
                    end
                    else
                    begin
                        seq_step = seq_step + 1;
                        seq_pos  = 0;
                    end
                end
                else
                begin
                    seq_pos = seq_pos + 1;
                end
            end
            default:
            begin
                if (seq_pos == 0)
                begin
                    w.value          = BYTE_CTRL_CMD;
                    w.transfer_first = 1'b1;
                    seq_pos          = 1;
                end
                else
                begin
                    w.value         = BYTE_TEST;
                    w.transfer_last = 1'b1;
                    w.sequence_last = 1'b1;
                    start_sequence(MODE_IDLE);
                end
            end
        endcase
        payload_due.push_back(w);
        return 1'b1;
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones, with calm stretches.
    function automatic int pick_gap();
        int r;
        if (back_to_back)
            return 0;
        if (tx_calm > 0)
        begin
            tx_calm = tx_calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            tx_calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        if (rx_calm > 0)
        begin
            rx_calm = rx_calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            rx_calm = $urandom_range(30, 150);
            return 0;
        end
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_command(input cmd_t c, input byte_t x, input byte_t y,
                                input logic on, input byte_t fill);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= c;
        req_ch.pixel_x   <= x;
        req_ch.pixel_y   <= y;
        req_ch.pixel_on  <= on;
        req_ch.fill_byte <= fill;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (stream_command(c, x, y, on, fill))
            items_taken = items_taken + 1;
    endtask

    task automatic send_tick();
        send_command(CMD_TICK, byte_t'($urandom), byte_t'($urandom), 1'($urandom),
                     byte_t'($urandom));
    endtask

    task automatic send_random_pixel();
        byte_t x;
        byte_t y;
        x = ($urandom_range(0, 99) < 85) ? byte_t'($urandom_range(0, COLUMNS - 1))
                                         : byte_t'($urandom_range(COLUMNS, 255));
        y = ($urandom_range(0, 99) < 85) ? byte_t'($urandom_range(0, ROWS - 1))
                                         : byte_t'($urandom_range(ROWS, 255));
        send_command(CMD_SET_PIXEL, x, y, 1'($urandom), byte_t'($urandom));
    endtask

    // Idle ticks and unused codes; the block must drop these silently.
    task automatic send_noise();
        cmd_t c;
        if ($urandom_range(0, 2) == 0)
            c = CMD_TICK;
        else
            c = cmd_t'(CMD_TICK + $urandom_range(1, 2));
        send_command(c, byte_t'($urandom), byte_t'($urandom), 1'($urandom),
                     byte_t'($urandom));
    endtask

    // Ticks the running sequence to its end, mixing in commands the block must ignore.
    task automatic run_sequence(input int busy_pct);
        cmd_t c;
        while (seq_mode != MODE_IDLE)
        begin
            if ($urandom_range(0, 99) < busy_pct)
            begin
                c = cmd_t'($urandom_range(0, 6));
                if (c >= CMD_TICK)
                    c = c + 3'd1;
                send_command(c, byte_t'($urandom), byte_t'($urandom), 1'($urandom),
                             byte_t'($urandom));
            end
            else
            begin
                send_tick();
            end
        end
    endtask

    task automatic wait_for_payload();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (payload_due.size() != 0)
            @(posedge clk);
    endtask

    // Registers change only with the block idle; fill and init may still be sweeping.
    task automatic settle();
        wait_for_payload();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input byte_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_BUS_ADDRESS)
            link_address = value[6:0];
        else if (idx == REG_CONTRAST)
            contrast_setting = value;
    endtask

    task automatic program_registers(input byte_t address_word, input byte_t contrast_word,
                                     input bit poke_unused);
        write_register(REG_BUS_ADDRESS, address_word);
        if (poke_unused)
            write_register(REG_FIRST_UNUSED + reg_index_t'($urandom_range(0, 253)),
                           byte_t'($urandom));
        write_register(REG_CONTRAST, contrast_word);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_idle_commands();
        send_command(CMD_TICK, 8'h00, 8'h00, 1'b0, 8'h00);
        send_command(CMD_TICK + 3'd1, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_TICK + 3'd2, 8'h00, 8'hFF, 1'b0, 8'h5A);
    endtask

    task automatic test_test_pattern();
        send_command(CMD_TEST, 8'h00, 8'h00, 1'b0, 8'h00);
        run_sequence(0);
        send_tick();
    endtask

    task automatic test_init_sequence();
        send_command(CMD_INIT, 8'h00, 8'h00, 1'b0, 8'hFF);
        run_sequence(25);
    endtask

    // Edge pixels on top of whatever earlier traffic left, then one flush reads all back.
    task automatic test_pixel_edges();
        send_command(CMD_SET_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00);
        send_command(CMD_SET_PIXEL, byte_t'(COLUMNS - 1), byte_t'(ROWS - 1), 1'b1, 8'h00);
        send_command(CMD_SET_PIXEL, byte_t'(COLUMNS), 8'd0, 1'b1, 8'h00);
        send_command(CMD_SET_PIXEL, 8'd0, byte_t'(ROWS), 1'b1, 8'h00);
        send_command(CMD_SET_PIXEL, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_SET_PIXEL, 8'd64, 8'd17, 1'b1, 8'h00);
        send_command(CMD_SET_PIXEL, 8'd64, 8'd16, 1'b1, 8'h00);
        send_command(CMD_SET_PIXEL, 8'd64, 8'd17, 1'b0, 8'h00);
        send_command(CMD_SET_PIXEL, 8'd3, 8'd7, 1'b0, 8'h00);
        send_command(CMD_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00);
        run_sequence(10);
    endtask

    task automatic test_fill();
        send_command(CMD_FILL, 8'h00, 8'h00, 1'b0, 8'hFF);
        run_sequence(0);
    endtask

    // The sink stops for a long stretch while ticks keep coming, then the sender pauses.
    task automatic test_receiver_holdoff();
        send_command(CMD_INIT, 8'h00, 8'h00, 1'b0, 8'h00);
        send_tick();
        back_to_back    = 1'b1;
        holdoff_request = 1'b1;
        repeat (20) send_tick();
        back_to_back = 1'b0;
        wait_for_payload();
        run_sequence(0);
    endtask

    task automatic test_random_traffic();
        int goal;
        int round;
        int pick;
        goal  = items_taken + RANDOM_ITEMS;
        round = 0;
        while (items_taken < goal)
        begin
            if (round % 4 == 3)
            begin
                settle();
                program_registers(byte_t'($urandom), byte_t'($urandom), 1'($urandom));
            end
            repeat ($urandom_range(3, 25))
            begin
                if ($urandom_range(0, 99) < 6)
                    send_noise();
                else
                    send_random_pixel();
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
                send_command(CMD_TEST, byte_t'($urandom), byte_t'($urandom), 1'b0, 8'h00);
            else
                send_command(CMD_INIT, byte_t'($urandom), byte_t'($urandom), 1'b1, 8'h00);
            run_sequence(8);
            round = round + 1;
        end
        // Leave random pixels behind for the closing flush to read back.
        repeat (40) send_random_pixel();
    endtask

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        payload_byte_t w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (payload_due.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected word, expected none, actual %0h", $time,
                         rsp_ch.byte_value);
            end
            else
            begin
                w = payload_due.pop_front();
                check_field("byte_value", w.value, rsp_ch.byte_value);
                check_field("transfer_first", w.transfer_first, rsp_ch.transfer_first);
                check_field("transfer_last", w.transfer_last, rsp_ch.transfer_last);
                check_field("sequence_last", w.sequence_last, rsp_ch.sequence_last);
                check_field("target_address", w.address, rsp_ch.target_address);
            end
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else if (rx_stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_stall_left = rx_stall_left - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                rx_stall_left = pick_stall();
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= CMD_TICK;
        req_ch.pixel_x   <= 8'h00;
        req_ch.pixel_y   <= 8'h00;
        req_ch.pixel_on  <= 1'b0;
        req_ch.fill_byte <= 8'h00;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_BUS_ADDRESS;
        cfg_ch.data      <= 8'h00;
        foreach (frame_image[i])
            frame_image[i] = 8'h00;
        start_sequence(MODE_IDLE);
        link_address     = BUS_ADDRESS_RESET;
        contrast_setting = CONTRAST_RESET;
        mismatches       = 0;
        items_taken      = 0;
        tx_calm          = 0;
        rx_calm          = 0;
        rx_stall_left    = 0;
        back_to_back     = 1'b0;
        holdoff_request  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_commands();
        test_test_pattern();
        settle();
        program_registers(8'h00, 8'hFF, 1'b1);
        test_init_sequence();
        settle();
        program_registers(8'hFF, 8'h00, 1'b0);
        test_init_sequence();
        test_fill();
        test_receiver_holdoff();
        settle();
        program_registers(byte_t'($urandom), byte_t'($urandom), 1'b1);
        test_random_traffic();
        test_pixel_edges();

        req_ch.valid <= 1'b0;
        while (payload_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (payload_due.size() != 0)
        begin
            mismatches = mismatches + 1;
            $display("%0t: words missing, expected %0d more, actual 0", $time,
                     payload_due.size());
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
